// ===== rtl/wuc_pkg.sv =====
// ----------------------------------------------------------------------------
// wuc_pkg
// Shared types and constants of the receive window credit return block.
// ----------------------------------------------------------------------------
package wuc_pkg;

  localparam int SIZE_W   = 24;
  localparam int SLOT_W   = 4;
  localparam int SID_W    = 31;
  localparam int WIN_W    = 31;
  localparam int CNT_W    = 32;
  localparam int CFG_IDX_W = 8;

  localparam int IN_DATA_W  = 64;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_CONN_WINDOW   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STREAM_WINDOW = 8'd1;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 31'd65535;
  localparam logic [SID_W-1:0] CONN_SID     = '0;

  localparam int RES_DEPTH = 4;
  localparam int RES_AW    = 2;

  typedef struct packed {
    logic [SID_W-1:0] update_stream;
    logic [WIN_W-1:0] increment;
    logic             last;
  } result_t;

  // Saturate a 33-bit sum to 32 bits.
  function automatic logic [CNT_W-1:0] sat32(input logic [CNT_W:0] s);
    logic [CNT_W-1:0] r;
    r = s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    return r;
  endfunction

  // Clip a counter to the 31-bit increment range.
  function automatic logic [WIN_W-1:0] clip31(input logic [CNT_W-1:0] v);
    logic [WIN_W-1:0] r;
    r = v[CNT_W-1] ? {WIN_W{1'b1}} : v[WIN_W-1:0];
    return r;
  endfunction

endpackage

// ===== rtl/wuc_slot_ram.sv =====
// ----------------------------------------------------------------------------
// wuc_slot_ram
// Per-slot byte counters: one write port, one registered read port.
// ----------------------------------------------------------------------------
module wuc_slot_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [wuc_pkg::CNT_W-1:0] rd_data,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [wuc_pkg::CNT_W-1:0] wr_data
);
  import wuc_pkg::*;

  logic [CNT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read returns the contents before a write at the same edge.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/wuc_result_fifo.sv =====
// ----------------------------------------------------------------------------
// wuc_result_fifo
// Small result queue taking up to two results a cycle and giving one.
// ----------------------------------------------------------------------------
module wuc_result_fifo (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [1:0]                    push_num,
  input  wuc_pkg::result_t              push0,
  input  wuc_pkg::result_t              push1,
  output logic [wuc_pkg::RES_AW:0]      count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output wuc_pkg::result_t              out_res
);
  import wuc_pkg::*;

  result_t           mem [RES_DEPTH];
  logic [RES_AW-1:0] wr_ptr;
  logic [RES_AW-1:0] rd_ptr;
  logic              pop;

  assign out_valid = (count != '0);
  assign out_res   = mem[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push_num != 2'd0) begin
      mem[wr_ptr] <= push0;
    end
    if (push_num == 2'd2) begin
      mem[wr_ptr + RES_AW'(1)] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RES_AW'(push_num);
      rd_ptr <= rd_ptr + RES_AW'(pop);
      count  <= count + (RES_AW+1)'(push_num) - (RES_AW+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (RES_AW+1)'(RES_DEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push_num == 2'd2 |-> count <= (RES_AW+1)'(RES_DEPTH - 2))
    else $error("two results pushed without room");

endmodule

// ===== rtl/window_update_credit_return_core.sv =====
// ----------------------------------------------------------------------------
// window_update_credit_return_core
// Receive-side flow control: accumulates received DATA bytes per connection
// and per stream slot and returns them as WINDOW_UPDATE increments.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  s_axis   | in        | frame size report (size, slot, stream id, flags)
//  m_axis   | out       | update (stream id, increment), tlast on final one
//  cfg      | in        | window register writes (index, data)
//
// An item passes through the slot counter read, then the update and write-back.
// One item is accepted per cycle while each item yields at most one update
// and m_axis_tready stays high; the two updates of one item leave in turn.
// After reset a clearing pass zeroes all slot counters with s_axis_tready
// low; configuration writes are taken throughout. The update stage stalls
// only when the four-entry result queue lacks room for two results.
// ----------------------------------------------------------------------------
module window_update_credit_return_core #(
  parameter int STREAM_SLOTS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [23:0] data_size, [27:24] stream_slot, [58:28] stream_number, rest zero
  input  logic [wuc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // [0] has_stream, [1] new_stream
  input  logic [wuc_pkg::IN_USER_W-1:0]  s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [30:0] update_stream, [61:31] increment, rest zero
  output logic [wuc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [wuc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wuc_pkg::WIN_W-1:0]      cfg_data
);
  import wuc_pkg::*;

  localparam int AW = (STREAM_SLOTS > 1) ? $clog2(STREAM_SLOTS) : 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(STREAM_SLOTS - 1);

  logic [WIN_W-1:0] conn_window;
  logic [WIN_W-1:0] stream_window;
  logic [CNT_W-1:0] conn_pending;

  logic          clr_active;
  logic [AW-1:0] clr_addr;

  // Input fields.
  logic [SIZE_W-1:0] in_size;
  logic [SLOT_W-1:0] in_slot;
  logic [SID_W-1:0]  in_sid;
  logic              in_has;
  logic              in_new;
  logic [31:0]       in_slot_ext;
  logic [AW-1:0]     in_addr;
  logic              in_slot_ok;
  logic              accept;

  // Update stage.
  logic              s1_valid;
  logic [SIZE_W-1:0] s1_size;
  logic [AW-1:0]     s1_addr;
  logic [SID_W-1:0]  s1_sid;
  logic              s1_stream;
  logic              s1_new;
  logic              s1_adv;
  logic              fwd;
  logic [CNT_W-1:0]  fwd_data;

  logic [CNT_W-1:0]  rd_data;
  logic [CNT_W-1:0]  conn_sum;
  logic              conn_fire;
  logic [CNT_W-1:0]  st_base;
  logic [CNT_W-1:0]  st_sum;
  logic              st_fire;
  logic [CNT_W-1:0]  st_store;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [CNT_W-1:0]  wr_data;

  result_t           conn_res;
  result_t           st_res;
  result_t           push0;
  result_t           push1;
  logic [1:0]        push_num;
  logic [RES_AW:0]   res_count;
  result_t           out_res;

  assign in_size     = s_axis_tdata[SIZE_W-1:0];
  assign in_slot     = s_axis_tdata[SIZE_W +: SLOT_W];
  assign in_sid      = s_axis_tdata[SIZE_W+SLOT_W +: SID_W];
  assign in_has      = s_axis_tuser[0];
  assign in_new      = s_axis_tuser[1];
  assign in_slot_ext = 32'(in_slot);
  assign in_addr     = in_slot_ext[AW-1:0];
  assign in_slot_ok  = (in_slot_ext < 32'(STREAM_SLOTS));

  // The update stage needs room for two results before it may retire.
  assign s1_adv        = (res_count <= (RES_AW+1)'(RES_DEPTH - 2));
  assign s_axis_tready = !clr_active && (!s1_valid || s1_adv);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      conn_window   <= WINDOW_RESET;
      stream_window <= WINDOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CONN_WINDOW:   conn_window   <= cfg_data;
        CFG_STREAM_WINDOW: stream_window <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      if (clr_addr == LAST_SLOT) begin
        clr_active <= 1'b0;
      end else begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  // Counter arithmetic of the update stage.
  always_comb begin
    conn_sum  = sat32({1'b0, conn_pending} + (CNT_W+1)'(s1_size));
    conn_fire = (conn_sum >= CNT_W'(conn_window[WIN_W-1:1])) && (conn_sum != '0);

    if (s1_new) begin
      st_base = '0;
    end else if (fwd) begin
      st_base = fwd_data;
    end else begin
      st_base = rd_data;
    end
    st_sum   = sat32({1'b0, st_base} + (CNT_W+1)'(s1_size));
    st_fire  = s1_stream && (st_sum >= CNT_W'(stream_window[WIN_W-1:1]))
               && (st_sum != '0);
    st_store = st_fire ? '0 : st_sum;

    conn_res.update_stream = CONN_SID;
    conn_res.increment     = clip31(conn_sum);
    conn_res.last          = !st_fire;
    st_res.update_stream   = s1_sid;
    st_res.increment       = clip31(st_sum);
    st_res.last            = 1'b1;

    push0    = conn_fire ? conn_res : st_res;
    push1    = st_res;
    push_num = 2'd0;
    if (s1_valid && s1_adv) begin
      push_num = 2'(conn_fire) + 2'(st_fire);
    end

    if (clr_active) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else begin
      wr_en   = s1_valid && s1_adv && s1_stream;
      wr_addr = s1_addr;
      wr_data = st_store;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      fwd          <= 1'b0;
      conn_pending <= '0;
    end else begin
      if (s1_valid && s1_adv) begin
        conn_pending <= conn_fire ? '0 : conn_sum;
      end
      if (accept) begin
        s1_valid <= 1'b1;
        // The slot read at this edge misses the write-back of the same edge.
        fwd      <= s1_valid && s1_stream && (s1_addr == in_addr);
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
        fwd      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_size   <= in_size;
      s1_addr   <= in_addr;
      s1_sid    <= in_sid;
      s1_stream <= in_has && in_slot_ok;
      s1_new    <= in_new;
      fwd_data  <= st_store;
    end
  end

  wuc_slot_ram #(
    .DEPTH (STREAM_SLOTS),
    .AW    (AW)
  ) u_slot_ram (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (in_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  wuc_result_fifo u_result_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_num  (push_num),
    .push0     (push0),
    .push1     (push1),
    .count     (res_count),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  assign m_axis_tdata = {{(OUT_DATA_W - SID_W - WIN_W){1'b0}},
                         out_res.increment, out_res.update_stream};
  assign m_axis_tlast = out_res.last;

  a_conn_cleared: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_adv && conn_fire |=> conn_pending == '0)
    else $error("connection counter not cleared after update");

  a_fwd_needs_item: assert property (@(posedge clk) disable iff (rst)
    fwd |-> s1_valid)
    else $error("forwarding flag without an item in the update stage");

  a_no_push_in_clear: assert property (@(posedge clk) disable iff (rst)
    clr_active |-> push_num == 2'd0 && !s1_valid)
    else $error("item in flight during the clearing pass");

endmodule
